### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks shared by the replacement RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/lfu_pkg.sv
// ----------------------------------------------------------------------------
// LFU replacement package
// Defaults and the control types passed along the frame cell chain.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int FRAMES_DEF     = 16;
  localparam int PAGE_BITS_DEF  = 20;
  localparam int COUNT_BITS_DEF = 16;

  localparam int LIMIT_W     = 5;   // frames_in_use register width
  localparam int SLOT_OUT_W  = 4;   // reported slot width
  localparam int FAULT_W     = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(16);

  // search token status, one hop per cycle along the chain
  typedef struct packed {
    logic active;   // token is at this position
    logic found;    // an earlier cell already matched
  } probe_ctl_t;

  // commit command broadcast to every cell
  typedef struct packed {
    logic wr;       // update the addressed cell this cycle
    logic hit;      // 1: bump use count, 0: load new page
  } commit_cmd_t;

endpackage

### hdl/lfu_cell.sv
// ----------------------------------------------------------------------------
// LFU frame cell
// Holds one frame and folds it into the passing match / minimum search.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfu_cell #(
  parameter int IDX        = 0,
  parameter int IDX_W      = 4,
  parameter int PAGE_BITS  = 20,
  parameter int COUNT_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,          // cell lies within the frame limit
  input  logic [PAGE_BITS-1:0]    key,
  input  lfu_pkg::probe_ctl_t     ctl_i,
  input  logic [IDX_W-1:0]        hit_slot_i,
  input  logic [IDX_W-1:0]        min_slot_i,
  input  logic [COUNT_BITS-1:0]   best_i,
  output lfu_pkg::probe_ctl_t     ctl_r,
  output logic [IDX_W-1:0]        hit_slot_r,
  output logic [IDX_W-1:0]        min_slot_r,
  output logic [COUNT_BITS-1:0]   best_r,
  input  lfu_pkg::commit_cmd_t    cmd,
  input  logic [IDX_W-1:0]        cmd_slot,
  input  logic [PAGE_BITS-1:0]    cmd_page
);
  import lfu_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);
  localparam bit FIRST = (IDX == 0);

  logic [PAGE_BITS-1:0]  page_r;
  logic                  valid_r;
  logic [COUNT_BITS-1:0] cnt_r;

  logic [COUNT_BITS-1:0] cnt_eff;
  logic                  match;
  logic                  take_min;
  logic                  sel;
  probe_ctl_t            ctl_nxt;

  assign cnt_eff  = valid_r ? cnt_r : '0;
  assign match    = en && valid_r && (page_r == key) && !ctl_i.found;
  assign take_min = en && (FIRST || (cnt_eff < best_i));
  assign sel      = cmd.wr && (cmd_slot == MY_IDX);

  always_comb begin
    ctl_nxt.active = ctl_i.active;
    ctl_nxt.found  = ctl_i.found | match;
  end

  // probe stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_slot_r <= match ? MY_IDX : hit_slot_i;
    min_slot_r <= take_min ? MY_IDX : min_slot_i;
    best_r     <= take_min ? cnt_eff : best_i;
  end

  // frame state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      cnt_r   <= '0;
    end else if (sel) begin
      if (cmd.hit) begin
        if (cnt_r != '1) begin
          cnt_r <= cnt_r + COUNT_BITS'(1);
        end
      end else begin
        valid_r <= 1'b1;
        cnt_r   <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sel && !cmd.hit) begin
      page_r <= cmd_page;
    end
  end

  // an empty frame never carries a use count
  `ASSERT_IMP(a_empty_zero, clk, rst_n, !valid_r, cnt_r == '0)
  // a fill leaves the frame resident with count one
  `ASSERT_NXT(a_fill, clk, rst_n, sel && !cmd.hit, valid_r && (cnt_r == COUNT_BITS'(1)))
  // an earlier match is never overridden downstream
  `ASSERT_NXT(a_first_hit, clk, rst_n, ctl_i.found, hit_slot_r == $past(hit_slot_i))

endmodule

### hdl/lfu_page_replacement.sv
// ----------------------------------------------------------------------------
// LFU page replacement
// Fully associative frame table with least-frequently-used replacement.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake            | Payload
//  --------+-----------+----------------------+------------------------------
//  in      | input     | in_valid / in_stall  | in_page_id
//  out     | output    | out_valid / out_stall| out_hit, out_frame_slot,
//          |           |                      | out_fault_total
//  cfg     | input     | cfg_we               | cfg_wdata (frames_in_use)
//
//  The search token walks the cell chain one frame per cycle, then the
//  tail result is latched and committed to the addressed cell.
//  Only one transaction is in flight; the next is accepted while the
//  previous result still waits in the output register.
//  Reset (synchronous, active low) empties every frame, zeros the fault
//  total and sets the frame limit to 16. No clearing pass is needed.
//  A stalled result holds the commit back until the output register frees.
// ----------------------------------------------------------------------------

module lfu_page_replacement #(
  parameter int FRAMES     = lfu_pkg::FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [PAGE_BITS-1:0]              in_page_id,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [lfu_pkg::SLOT_OUT_W-1:0]    out_frame_slot,
  output logic [lfu_pkg::FAULT_W-1:0]       out_fault_total,
  // configuration
  input  logic                              cfg_we,
  input  logic [lfu_pkg::LIMIT_W-1:0]       cfg_wdata
);
  import lfu_pkg::*;

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NW    = $clog2(FRAMES + 1);
  localparam int LW    = (NW > LIMIT_W) ? NW : LIMIT_W;   // limit compare width

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [LIMIT_W-1:0]      limit_r;
  logic [PAGE_BITS-1:0]    key_r;
  logic                    tok_r;
  logic                    res_hit_r;
  logic [IDX_W-1:0]        res_slot_r;
  logic [FAULT_W-1:0]      fault_r, fault_nxt;
  logic                    out_valid_r;
  logic                    out_hit_r;
  logic [SLOT_OUT_W-1:0]   out_slot_r;
  logic [FAULT_W-1:0]      out_fault_r;

  logic                    accept;
  logic                    out_free;
  logic                    commit;
  logic [LW-1:0]           limit_ext;
  logic [LW-1:0]           n_eff;
  logic [FRAMES-1:0]       en;
  logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;
  commit_cmd_t             cmd;

  // chain links: index k feeds cell k, index FRAMES is the tail
  probe_ctl_t              ctl_l  [FRAMES+1];
  logic [IDX_W-1:0]        hslot_l[FRAMES+1];
  logic [IDX_W-1:0]        mslot_l[FRAMES+1];
  logic [COUNT_BITS-1:0]   best_l [FRAMES+1];

  // ---- handshakes --------------------------------------------------------
  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign commit    = (state_r == ST_COMMIT) && out_free;

  // ---- effective frame limit: zero acts as one, clipped to FRAMES -------
  assign limit_ext = LW'(limit_r);
  always_comb begin
    if (limit_r == '0) begin
      n_eff = LW'(1);
    end else if (limit_ext > LW'(FRAMES)) begin
      n_eff = LW'(FRAMES);
    end else begin
      n_eff = limit_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
    end else if (cfg_we) begin
      limit_r <= cfg_wdata;
    end
  end

  // ---- chain head: fresh token, nothing found yet ------------------------
  always_comb begin
    ctl_l[0].active = tok_r;
    ctl_l[0].found  = 1'b0;
  end
  assign hslot_l[0] = '0;
  assign mslot_l[0] = '0;
  assign best_l[0]  = '0;

  assign cmd.wr  = commit;
  assign cmd.hit = res_hit_r;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    assign en[i] = (LW'(i) < n_eff);

    lfu_cell #(
      .IDX        (i),
      .IDX_W      (IDX_W),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en[i]),
      .key        (key_r),
      .ctl_i      (ctl_l[i]),
      .hit_slot_i (hslot_l[i]),
      .min_slot_i (mslot_l[i]),
      .best_i     (best_l[i]),
      .ctl_r      (ctl_l[i+1]),
      .hit_slot_r (hslot_l[i+1]),
      .min_slot_r (mslot_l[i+1]),
      .best_r     (best_l[i+1]),
      .cmd        (cmd),
      .cmd_slot   (res_slot_r),
      .cmd_page   (key_r)
    );
  end

  // ---- sequencer ---------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (accept) state_nxt = ST_SEARCH;
      ST_SEARCH: if (ctl_l[FRAMES].active) state_nxt = ST_COMMIT;
      ST_COMMIT: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      tok_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tok_r   <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r <= in_page_id;
    end
  end

  // tail of the chain: first match wins, otherwise the minimum holder
  always_ff @(posedge clk) begin
    if ((state_r == ST_SEARCH) && ctl_l[FRAMES].active) begin
      res_hit_r  <= ctl_l[FRAMES].found;
      res_slot_r <= ctl_l[FRAMES].found ? hslot_l[FRAMES] : mslot_l[FRAMES];
    end
  end

  // ---- fault total, saturating ------------------------------------------
  assign fault_nxt = (!res_hit_r && (fault_r != '1)) ? fault_r + FAULT_W'(1) : fault_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r <= '0;
    end else if (commit) begin
      fault_r <= fault_nxt;
    end
  end

  // ---- output register ---------------------------------------------------
  assign slot_ext = {{SLOT_OUT_W{1'b0}}, res_slot_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r   <= res_hit_r;
      out_slot_r  <= slot_ext[SLOT_OUT_W-1:0];
      out_fault_r <= fault_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_frame_slot  = out_slot_r;
  assign out_fault_total = out_fault_r;

endmodule
